FILE: hw/rtl/pps_pkg.sv
// Shared types, sizes and codes for the preemptive priority scheduler.
// Used by pps_pick, preemptive_priority_scheduler_top and the testbench; depends on nothing.
package pps_pkg;

   localparam int SLOT_COUNT    = 8;
   localparam int TIME_BITS     = 16;
   localparam int SLOT_BITS     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int PRI_BITS      = 4;
   localparam int BURST_BITS    = 8;
   localparam int ID_BITS       = 3;
   localparam int OUT_SLOT_BITS = 3;
   localparam int OUT_TIME_BITS = 16;
   localparam int TREE_LEAVES   = 1 << SLOT_BITS;
   localparam int KEY_BITS      = PRI_BITS + TIME_BITS + SLOT_BITS;

   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [PRI_BITS-1:0]   pri_type;
   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [BURST_BITS-1:0] burst_type;
   typedef logic [KEY_BITS-1:0]   key_type;

   typedef enum logic {
      REQ_ARRIVE = 1'b0,
      REQ_TICK   = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'd0,
      ST_REJECT = 2'd1,
      ST_RAN    = 2'd2,
      ST_IDLE   = 2'd3
   } status_type;

   // Winner of the priority tree.
   typedef struct packed {
      logic     valid;
      slot_type slot;
      pri_type  pri;
   } pick_type;

endpackage

FILE: hw/rtl/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler: request register, slot table, pick tree
// and result register. Depends on pps_pkg and pps_pick.
//
// Usage:
//   The req_ channel carries one word per operation: req_type low loads a
//   task into slot req_task_id with req_task_priority and req_burst_length;
//   req_type high is one time tick that runs the selected task for one unit.
//   The rsp_ channel returns exactly one word per request, in order, with a
//   status, the slot that ran, and on completion the turnaround and waiting
//   times of the finished task.
//   A request is taken into the request register on the edge where req_valid
//   is high and req_stall is low; its result is loaded into the result
//   register on the next edge the result register is free. One request per
//   cycle is sustained while rsp_stall is low: the pick tree, the slot
//   update and the clock update all settle combinationally between the two
//   registers. When rsp_stall holds a result and the request register is
//   empty, it still takes one more word; req_stall is high whenever it holds
//   a word and the result is not taken.
//   Synchronous reset empties both registers, marks every slot free, clears
//   the time counter and forgets the last running task.
module preemptive_priority_scheduler_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [pps_pkg::ID_BITS-1:0]        req_task_id,
   input  logic [pps_pkg::PRI_BITS-1:0]       req_task_priority,
   input  logic [pps_pkg::BURST_BITS-1:0]     req_burst_length,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [pps_pkg::OUT_SLOT_BITS-1:0]  rsp_run_slot,
   output logic                               rsp_finished,
   output logic [pps_pkg::OUT_TIME_BITS-1:0]  rsp_turnaround_time,
   output logic [pps_pkg::OUT_TIME_BITS-1:0]  rsp_wait_time
);
   import pps_pkg::*;

   // Request register.
   logic                hold_valid_ff, hold_valid_in;
   logic                hold_type_ff;
   logic [ID_BITS-1:0]  hold_id_ff;
   pri_type             hold_pri_ff;
   burst_type           hold_burst_ff;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [OUT_SLOT_BITS-1:0] rsp_slot_ff, rsp_slot_in;
   logic                     rsp_fin_ff, rsp_fin_in;
   logic [OUT_TIME_BITS-1:0] rsp_tat_ff, rsp_tat_in;
   logic [OUT_TIME_BITS-1:0] rsp_wt_ff, rsp_wt_in;

   // Scheduler state.
   time_type               now_ff, now_in;
   logic [SLOT_COUNT-1:0]  pending_ff, pending_in;
   logic                   last_valid_ff, last_valid_in;
   slot_type               last_slot_ff, last_slot_in;
   pri_type                slot_pri_ff [SLOT_COUNT];
   pri_type                slot_pri_in [SLOT_COUNT];
   burst_type              slot_rem_ff [SLOT_COUNT];
   burst_type              slot_rem_in [SLOT_COUNT];
   burst_type              slot_burst_ff [SLOT_COUNT];
   burst_type              slot_burst_in [SLOT_COUNT];
   time_type               slot_arr_ff [SLOT_COUNT];
   time_type               slot_arr_in [SLOT_COUNT];

   time_type               slot_age [SLOT_COUNT];
   pick_type               pick;

   logic out_free;
   logic fire;

   logic [SLOT_COUNT-1:0] id_hit, last_hit, run_hit;
   logic                  id_ok, busy, arrive_ok;
   pri_type               last_pri;
   logic                  keep_last;
   slot_type              run_slot;
   burst_type             sel_rem, rem_next;
   burst_type             sel_burst;
   time_type              sel_arr, now_next, tat, wt;
   logic                  done;

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign req_stall     = hold_valid_ff && !out_free;
   assign fire          = hold_valid_ff && out_free;
   assign hold_valid_in = req_stall ? hold_valid_ff : req_valid;
   assign rsp_valid_in  = out_free ? hold_valid_ff : rsp_valid_ff;

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_age[i] = now_ff - slot_arr_ff[i];
      end
   end

   pps_pick u_pick (
      .pending  (pending_ff),
      .slot_pri (slot_pri_ff),
      .slot_age (slot_age),
      .pick     (pick)
   );

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         id_hit[i]   = (32'(hold_id_ff) == 32'(i));
         last_hit[i] = (last_slot_ff == SLOT_BITS'(i));
      end
      id_ok     = 32'(hold_id_ff) < 32'(SLOT_COUNT);
      busy      = |(pending_ff & id_hit);
      arrive_ok = id_ok && (hold_burst_ff != '0) && !busy;

      last_pri = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (last_hit[i]) begin
            last_pri = last_pri | slot_pri_ff[i];
         end
      end
      // The task that ran last keeps the slot unless a pending task has strictly
      // higher priority.
      keep_last = last_valid_ff && (|(pending_ff & last_hit)) && (last_pri >= pick.pri);
      run_slot  = keep_last ? last_slot_ff : pick.slot;

      sel_rem   = '0;
      sel_burst = '0;
      sel_arr   = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         run_hit[i] = (run_slot == SLOT_BITS'(i));
         if (run_hit[i]) begin
            sel_rem   = sel_rem | slot_rem_ff[i];
            sel_burst = sel_burst | slot_burst_ff[i];
            sel_arr   = sel_arr | slot_arr_ff[i];
         end
      end
      now_next = now_ff + TIME_BITS'(1);
      rem_next = sel_rem - BURST_BITS'(1);
      done     = (rem_next == '0);
      tat      = now_next - sel_arr;
      wt       = tat - TIME_BITS'(sel_burst);

      now_in        = now_ff;
      pending_in    = pending_ff;
      last_valid_in = last_valid_ff;
      last_slot_in  = last_slot_ff;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_pri_in[i]   = slot_pri_ff[i];
         slot_rem_in[i]   = slot_rem_ff[i];
         slot_burst_in[i] = slot_burst_ff[i];
         slot_arr_in[i]   = slot_arr_ff[i];
      end

      rsp_status_in = ST_REJECT;
      rsp_slot_in   = '0;
      rsp_fin_in    = 1'b0;
      rsp_tat_in    = '0;
      rsp_wt_in     = '0;

      if (hold_type_ff == REQ_ARRIVE) begin
         if (arrive_ok) begin
            rsp_status_in = ST_ACCEPT;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (id_hit[i]) begin
                  pending_in[i]    = 1'b1;
                  slot_pri_in[i]   = hold_pri_ff;
                  slot_rem_in[i]   = hold_burst_ff;
                  slot_burst_in[i] = hold_burst_ff;
                  slot_arr_in[i]   = now_ff;
               end
            end
         end
      end else begin
         now_in = now_next;
         if (!pick.valid) begin
            rsp_status_in = ST_IDLE;
            last_valid_in = 1'b0;
         end else begin
            rsp_status_in = ST_RAN;
            rsp_slot_in   = OUT_SLOT_BITS'(run_slot);
            last_slot_in  = run_slot;
            last_valid_in = !done;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (run_hit[i]) begin
                  slot_rem_in[i] = rem_next;
                  if (done) begin
                     pending_in[i] = 1'b0;
                  end
               end
            end
            if (done) begin
               rsp_fin_in = 1'b1;
               rsp_tat_in = OUT_TIME_BITS'(tat);
               rsp_wt_in  = OUT_TIME_BITS'(wt);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         now_ff        <= '0;
         pending_ff    <= '0;
         last_valid_ff <= 1'b0;
         last_slot_ff  <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (fire) begin
            now_ff        <= now_in;
            pending_ff    <= pending_in;
            last_valid_ff <= last_valid_in;
            last_slot_ff  <= last_slot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         hold_type_ff  <= req_type;
         hold_id_ff    <= req_task_id;
         hold_pri_ff   <= req_task_priority;
         hold_burst_ff <= req_burst_length;
      end
      if (fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_fin_ff    <= rsp_fin_in;
         rsp_tat_ff    <= rsp_tat_in;
         rsp_wt_ff     <= rsp_wt_in;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_pri_ff[i]   <= slot_pri_in[i];
            slot_rem_ff[i]   <= slot_rem_in[i];
            slot_burst_ff[i] <= slot_burst_in[i];
            slot_arr_ff[i]   <= slot_arr_in[i];
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_run_slot        = rsp_slot_ff;
   assign rsp_finished        = rsp_fin_ff;
   assign rsp_turnaround_time = rsp_tat_ff;
   assign rsp_wait_time       = rsp_wt_ff;

endmodule

FILE: hw/rtl/pps_pick.sv
// Priority tree that picks the most urgent pending slot: highest priority,
// then oldest arrival, then lowest slot. Depends on pps_pkg.
module pps_pick (
   input  logic [pps_pkg::SLOT_COUNT-1:0] pending,
   input  pps_pkg::pri_type               slot_pri [pps_pkg::SLOT_COUNT],
   input  pps_pkg::time_type              slot_age [pps_pkg::SLOT_COUNT],
   output pps_pkg::pick_type              pick
);
   import pps_pkg::*;

   localparam int NODES = 2 * TREE_LEAVES - 1;

   logic    node_valid [NODES];
   key_type node_key   [NODES];

   // The key orders by priority, then age, then inverted slot number, so a
   // plain unsigned maximum gives the wanted winner and is never a tie.
   for (genvar g = 0; g < TREE_LEAVES; g++) begin : g_leaf
      if (g < SLOT_COUNT) begin : g_real
         assign node_valid[TREE_LEAVES-1+g] = pending[g];
         assign node_key[TREE_LEAVES-1+g]   = {slot_pri[g], slot_age[g], ~SLOT_BITS'(g)};
      end else begin : g_pad
         assign node_valid[TREE_LEAVES-1+g] = 1'b0;
         assign node_key[TREE_LEAVES-1+g]   = '0;
      end
   end

   for (genvar n = 0; n < TREE_LEAVES - 1; n++) begin : g_node
      localparam int L = 2 * n + 1;
      localparam int R = 2 * n + 2;
      logic take_right;
      assign take_right    = node_valid[R] &&
                             (!node_valid[L] || (node_key[R] > node_key[L]));
      assign node_valid[n] = node_valid[L] || node_valid[R];
      assign node_key[n]   = take_right ? node_key[R] : node_key[L];
   end

   assign pick.valid = node_valid[0];
   assign pick.pri   = node_key[0][KEY_BITS-1 -: PRI_BITS];
   assign pick.slot  = ~node_key[0][SLOT_BITS-1:0];

endmodule

FILE: verif/tb_preemptive_priority_scheduler_top.sv
// Self-checking testbench for preemptive_priority_scheduler_top: a directed pass,
// random arrival and tick traffic, a stretch without idles, a drain pause and a long mixed run.
// Depends on pps_pkg and the scheduler RTL; needs no files or arguments.
module tb_preemptive_priority_scheduler_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pps_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int IDLE_PCT    = 6;
   localparam int MAX_REPORTS = 20;

   typedef struct packed {
      status_type         status;
      logic [2:0]         run_slot;
      logic               finished;
      logic [15:0]        turnaround;
      logic [15:0]        waiting;
   } sched_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = 1'b0;
   logic [2:0]  req_task_id = '0;
   logic [3:0]  req_task_priority = '0;
   logic [7:0]  req_burst_length = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_run_slot;
   logic        rsp_finished;
   logic [15:0] rsp_turnaround_time;
   logic [15:0] rsp_wait_time;

   // Predicted scheduler state.
   time_type   clock_now = '0;
   logic       slot_busy [SLOT_COUNT] = '{default: 1'b0};
   pri_type    slot_pri [SLOT_COUNT];
   burst_type  slot_left [SLOT_COUNT];
   burst_type  slot_len [SLOT_COUNT];
   time_type   slot_stamp [SLOT_COUNT];
   logic       last_valid = 1'b0;
   int         last_slot = 0;

   sched_outcome_type outcome_queue [$];

   logic calm = 1'b0;
   int   mismatch_count = 0;
   int   words_checked = 0;
   int   cycle_count = 0;
   int   finish_count = 0;
   int   preempt_count = 0;
   int   reject_count = 0;
   int   wrap_count = 0;

   preemptive_priority_scheduler_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_task_id         (req_task_id),
      .req_task_priority   (req_task_priority),
      .req_burst_length    (req_burst_length),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_run_slot        (rsp_run_slot),
      .rsp_finished        (rsp_finished),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_wait_time       (rsp_wait_time)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, outcome_queue.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   // Works out the result of one accepted word and updates the predicted state.
   function automatic sched_outcome_type predict_sched_outcome(req_kind_type kind,
         logic [2:0] id, pri_type pri, burst_type burst);
      sched_outcome_type r;
      int chosen;
      int best_pri;
      time_type best_age;
      time_type age;
      time_type tat;
      r = '0;
      r.status = ST_ACCEPT;
      if (kind == REQ_ARRIVE) begin
         if (burst == '0 || slot_busy[id]) begin
            r.status = ST_REJECT;
            reject_count++;
         end else begin
            slot_busy[id]  = 1'b1;
            slot_pri[id]   = pri;
            slot_left[id]  = burst;
            slot_len[id]   = burst;
            slot_stamp[id] = clock_now;
         end
         return r;
      end
      chosen = -1;
      best_pri = -1;
      best_age = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (!slot_busy[i]) continue;
         age = clock_now - slot_stamp[i];
         if (chosen < 0 || int'(slot_pri[i]) > best_pri ||
             (int'(slot_pri[i]) == best_pri && age > best_age)) begin
            chosen = i;
            best_pri = slot_pri[i];
            best_age = age;
         end
      end
      // The running task holds on unless someone has strictly higher priority.
      if (chosen >= 0 && last_valid && slot_busy[last_slot]) begin
         if (int'(slot_pri[last_slot]) >= best_pri) chosen = last_slot;
         else preempt_count++;
      end
      clock_now = clock_now + 1'b1;
      if (clock_now == '0) wrap_count++;
      if (chosen < 0) begin
         last_valid = 1'b0;
         r.status = ST_IDLE;
         return r;
      end
      r.status = ST_RAN;
      r.run_slot = chosen[2:0];
      slot_left[chosen] = slot_left[chosen] - 1'b1;
      last_slot = chosen;
      if (slot_left[chosen] == '0) begin
         tat = clock_now - slot_stamp[chosen];
         r.finished = 1'b1;
         r.turnaround = tat;
         r.waiting = tat - time_type'(slot_len[chosen]);
         slot_busy[chosen] = 1'b0;
         last_valid = 1'b0;
         finish_count++;
      end else begin
         last_valid = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("mismatch on word %0d: %s got %0h expected %0h",
                  words_checked, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_words
      sched_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_queue.size() == 0) begin
            report_mismatch("word with nothing outstanding", 16'(rsp_status), '0);
         end else begin
            want = outcome_queue.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 16'(rsp_status), 16'(want.status));
            if (rsp_run_slot !== want.run_slot)
               report_mismatch("run_slot", 16'(rsp_run_slot), 16'(want.run_slot));
            if (rsp_finished !== want.finished)
               report_mismatch("finished", 16'(rsp_finished), 16'(want.finished));
            if (rsp_turnaround_time !== want.turnaround)
               report_mismatch("turnaround", rsp_turnaround_time, want.turnaround);
            if (rsp_wait_time !== want.waiting)
               report_mismatch("wait", rsp_wait_time, want.waiting);
         end
         words_checked++;
      end
   end

   // Sends one word and records its predicted result once it is taken.
   task automatic send_word(req_kind_type kind, logic [2:0] id, pri_type pri,
                            burst_type burst);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_task_id <= id;
      req_task_priority <= pri;
      req_burst_length <= burst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      outcome_queue.push_back(predict_sched_outcome(kind, id, pri, burst));
   endtask

   // Fields other than the kind are don't-care on a tick, so they carry noise.
   task automatic send_tick();
      send_word(REQ_TICK, 3'($urandom_range(7)), 4'($urandom_range(15)),
                8'($urandom_range(255)));
   endtask

   task automatic send_random_word(int tick_pct);
      int free_slots [$];
      logic [2:0] id;
      pri_type pri;
      burst_type burst;
      int roll;
      if ($urandom_range(99) < tick_pct) begin
         send_tick();
      end else begin
         for (int i = 0; i < SLOT_COUNT; i++)
            if (!slot_busy[i]) free_slots.push_back(i);
         if (free_slots.size() != 0 && $urandom_range(99) < 75)
            id = 3'(free_slots[$urandom_range(free_slots.size() - 1)]);
         else
            id = 3'($urandom_range(7));
         // A narrow priority band makes ties and arrival order matter.
         if ($urandom_range(1)) pri = 4'($urandom_range(5, 3));
         else pri = 4'($urandom_range(15));
         roll = $urandom_range(99);
         if (roll < 1) burst = '0;
         else if (roll < 85) burst = 8'($urandom_range(6, 1));
         else if (roll < 97) burst = 8'($urandom_range(40, 7));
         else burst = 8'($urandom_range(255, 41));
         send_word(REQ_ARRIVE, id, pri, burst);
      end
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outcome_queue.size() != 0);
   endtask

   task automatic test_directed_cases();
      send_tick();                               // idle tick on an empty table
      send_word(REQ_ARRIVE, 3'd0, 4'd0, 8'd1);
      send_word(REQ_ARRIVE, 3'd0, 4'd5, 8'd3);   // slot already busy
      send_word(REQ_ARRIVE, 3'd1, 4'd0, 8'd0);   // zero burst
      send_tick();
      send_word(REQ_ARRIVE, 3'd5, 4'd4, 8'd3);
      send_word(REQ_ARRIVE, 3'd3, 4'd4, 8'd2);   // same stamp, lower slot wins
      send_tick();
      send_word(REQ_ARRIVE, 3'd6, 4'd4, 8'd1);   // equal priority does not preempt
      send_tick();
      send_tick();
      send_word(REQ_ARRIVE, 3'd7, 4'd15, 8'd2);  // strictly higher priority preempts
      send_tick();
      send_word(REQ_ARRIVE, 3'd2, 4'd0, 8'd255);
      send_word(REQ_ARRIVE, 3'd4, 4'd9, 8'd128);
      send_tick();
      send_tick();
      send_tick();
      send_tick();
      send_tick();
   endtask

   task automatic test_random_traffic(int count);
      repeat (count) send_random_word(65);
   endtask

   task automatic test_no_idle_stretch(int count);
      calm = 1'b1;
      repeat (count) send_random_word(60);
      calm = 1'b0;
   endtask

   task automatic test_pause_until_drained();
      repeat (150) send_random_word(55);
      wait_until_drained();
      repeat (150) send_random_word(70);
   endtask

   // A long mixed run with a lower tick share keeps the table crowded.
   task automatic test_long_traffic();
      repeat (600) send_random_word(55);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_traffic(700);
      test_no_idle_stretch(300);
      test_pause_until_drained();
      test_long_traffic();
      wait_until_drained();
      repeat (10) @(posedge clock);
      $display("Checked %0d result words: %0d tasks completed, %0d preemptions,",
               words_checked, finish_count, preempt_count);
      $display("%0d rejected arrivals, time stamp wrapped %0d time(s).",
               reject_count, wrap_count);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/pps_pkg.sv
hw/rtl/pps_pick.sv
hw/rtl/preemptive_priority_scheduler_top.sv
verif/tb_preemptive_priority_scheduler_top.sv
